// File: rtl/core/amstep_pkg.sv
`timescale 1ns / 1ps

package amstep_pkg;

    // Machine geometry. MEM_WORDS must be a power of two so that address
    // arithmetic wraps by simple truncation.
    localparam int MEM_WORDS = 1024;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(MEM_WORDS);

    // Fixed widths of the channel fields.
    localparam int ACT_BITS  = 2;
    localparam int FADR_BITS = 10;
    localparam int FVAL_BITS = 32;
    localparam int CFG_BITS  = 10;
    localparam int CIDX_BITS = 1;

    typedef logic [ADDR_BITS-1:0]        addr_t;
    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [CFG_BITS-1:0]         cfg_t;

    localparam cfg_t  START_PC_RESET   = CFG_BITS'(0);
    localparam cfg_t  STACK_INIT_RESET = CFG_BITS'(1023);
    localparam addr_t SP_RESET         = ADDR_BITS'(1023 % MEM_WORDS);

    typedef enum logic [CIDX_BITS-1:0] {
        CFG_START_PC   = 1'b0,
        CFG_STACK_INIT = 1'b1
    } cfg_idx_t;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_STEP    = 2'd2
    } act_t;

    typedef enum logic [4:0] {
        OP_BAD   = 5'd0,
        OP_LOAD  = 5'd1,
        OP_STORE = 5'd2,
        OP_PUSH  = 5'd3,
        OP_POP   = 5'd4,
        OP_JMP   = 5'd5,
        OP_JPG   = 5'd6,
        OP_JPGE  = 5'd7,
        OP_JPL   = 5'd8,
        OP_JPLE  = 5'd9,
        OP_JPE   = 5'd10,
        OP_JPNE  = 5'd11,
        OP_XOR   = 5'd12,
        OP_AND   = 5'd13,
        OP_OR    = 5'd14,
        OP_NOT   = 5'd15,
        OP_ADD   = 5'd16,
        OP_SUB   = 5'd17,
        OP_READ  = 5'd18,
        OP_WRITE = 5'd19,
        OP_CALL  = 5'd20,
        OP_RET   = 5'd21,
        OP_HALT  = 5'd22
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARGRD,
        S_EA,
        S_EXEC,
        S_FINISH
    } state_t;

    // Maps a fetched memory word onto an opcode; any word outside the
    // defined set decodes as an illegal instruction.
    function automatic op_t decode_op(input logic [WORD_BITS-1:0] w);
        op_t op;
        op = OP_BAD;
        if (w >= WORD_BITS'(1) && w <= WORD_BITS'(22)) begin
            op = op_t'(w[4:0]);
        end
        return op;
    endfunction

endpackage

// File: rtl/core/amstep_if.sv
`timescale 1ns / 1ps

// Request channel: one load, restart or step command per transfer.
interface amstep_cmd_if;
    import amstep_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ACT_BITS-1:0]          action;
    logic [FADR_BITS-1:0]         address;
    logic signed [FVAL_BITS-1:0]  data;
    logic signed [FVAL_BITS-1:0]  read_value;

    modport source (output valid, output action, output address, output data,
                    output read_value, input ready);
    modport sink   (input valid, input action, input address, input data,
                    input read_value, output ready);
endinterface

// Result channel: machine status after each request.
interface amstep_rsp_if;
    import amstep_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         out_valid;
    logic signed [FVAL_BITS-1:0]  out_value;
    logic                         halted;
    logic                         fault;
    logic [FADR_BITS-1:0]         pc_now;
    logic signed [FVAL_BITS-1:0]  acc_now;

    modport source (output valid, output out_valid, output out_value,
                    output halted, output fault, output pc_now, output acc_now,
                    input ready);
    modport sink   (input valid, input out_valid, input out_value,
                    input halted, input fault, input pc_now, input acc_now,
                    output ready);
endinterface

// Configuration register write channel.
interface amstep_cfg_if;
    import amstep_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CIDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/accumulator_machine_step.sv
// A load, a restart or a step on a halted machine goes from the idle state straight to
// S_FINISH; an executed instruction goes through S_ARGRD and S_EA, then through S_EXEC
// when it reads a data word (LOAD, XOR, AND, OR, ADD, SUB, WRITE, PUSH, POP, RET), then
// S_FINISH, which waits for a free result register. A new request is taken only in idle,
// after the last one is through; the single memory port serves opcode fetch, operand fetch and the data access in turn.
// Reset sets PC 0, SP 1023, accumulator 0, stop flag 0, config to defaults, no handshake.
`timescale 1ns / 1ps

module accumulator_machine_step (
    input  logic                clk,
    input  logic                rst_n,
    amstep_cfg_if.sink          cfg,
    amstep_cmd_if.sink          cmd,
    amstep_rsp_if.source        rsp
);
    import amstep_pkg::*;

    // Program and data memory: one port, read data registered.
    word_t  mem [MEM_WORDS];
    word_t  rdata_reg;
    addr_t  mem_addr;
    logic   mem_we;
    word_t  mem_wdata;

    // Sequencer and architectural state.
    state_t state_reg, state_next;
    addr_t  pc_reg, pc_next;
    addr_t  sp_reg, sp_next;
    word_t  acc_reg, acc_next;
    logic   stopped_reg, stopped_next;
    cfg_t   start_pc_reg;
    cfg_t   stack_init_reg;

    // Per-instruction working registers.
    op_t    op_reg, op_next;
    addr_t  ea_reg, ea_next;
    word_t  rv_reg, rv_next;
    logic   fault_reg, fault_next;
    logic   wvalid_reg, wvalid_next;
    word_t  wvalue_reg, wvalue_next;

    // Result register.
    logic   rsp_valid_reg, rsp_valid_next;
    logic   rsp_load;
    logic   rsp_out_valid_reg;
    word_t  rsp_out_value_reg;
    logic   rsp_halted_reg;
    logic   rsp_fault_reg;
    addr_t  rsp_pc_reg;
    word_t  rsp_acc_reg;

    addr_t  p1;
    addr_t  ea_calc;
    addr_t  sp_dec;
    logic   acc_neg;
    logic   acc_zero;

    assign p1       = pc_reg + 1'b1;
    assign ea_calc  = p1 + rdata_reg[ADDR_BITS-1:0];
    assign sp_dec   = sp_reg - 1'b1;
    assign acc_neg  = acc_reg[WORD_BITS-1];
    assign acc_zero = (acc_reg == '0);

    // The configuration registers are always writable; the user must write them only
    // while the machine is idle, and the block itself does not enforce this.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg   <= START_PC_RESET;
            stack_init_reg <= STACK_INIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_START_PC:   start_pc_reg   <= cfg.wdata;
                CFG_STACK_INIT: stack_init_reg <= cfg.wdata;
                default:        ;
            endcase
        end
    end

    // Single-port memory, read-before-write.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    assign cmd.ready = (state_reg == S_IDLE);

    // Sequencer. Each instruction walks the memory port through operand fetch,
    // then an optional data read, then the final write-back if any. The opcode
    // read is issued in the idle state itself, since the memory address rests on
    // the PC there.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        acc_next       = acc_reg;
        stopped_next   = stopped_reg;
        op_next        = op_reg;
        ea_next        = ea_reg;
        rv_next        = rv_reg;
        fault_next     = fault_reg;
        wvalid_next    = wvalid_reg;
        wvalue_next    = wvalue_reg;
        mem_addr       = pc_reg;
        mem_we         = 1'b0;
        mem_wdata      = acc_reg;
        rsp_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    rv_next     = cmd.read_value;
                    fault_next  = 1'b0;
                    wvalid_next = 1'b0;
                    wvalue_next = '0;
                    state_next  = S_FINISH;
                    case (act_t'(cmd.action))
                        ACT_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = cmd.address[ADDR_BITS-1:0];
                            mem_wdata = cmd.data;
                        end
                        ACT_RESTART:
                        begin
                            pc_next      = start_pc_reg[ADDR_BITS-1:0];
                            sp_next      = stack_init_reg[ADDR_BITS-1:0];
                            acc_next     = '0;
                            stopped_next = 1'b0;
                        end
                        ACT_STEP:
                        begin
                            // A halted machine ignores steps and just reports.
                            if (!stopped_reg)
                            begin
                                state_next = S_ARGRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_ARGRD:
            begin
                // The opcode word is back; fetch the offset word after it.
                mem_addr   = p1;
                op_next    = decode_op(rdata_reg);
                state_next = S_EA;
            end

            S_EA:
            begin
                // The offset word is back, so the effective address is known.
                ea_next    = ea_calc;
                pc_next    = p1 + 1'b1;
                state_next = S_FINISH;
                case (op_reg)
                    OP_LOAD, OP_XOR, OP_AND, OP_OR, OP_ADD, OP_SUB, OP_WRITE,
                    OP_PUSH:
                    begin
                        mem_addr   = ea_calc;
                        state_next = S_EXEC;
                    end
                    OP_POP, OP_RET:
                    begin
                        mem_addr   = sp_reg;
                        state_next = S_EXEC;
                    end
                    OP_STORE:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = ea_calc;
                        mem_wdata = acc_reg;
                    end
                    OP_READ:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = ea_calc;
                        mem_wdata = rv_reg;
                    end
                    OP_JMP:  pc_next = ea_calc + 1'b1;
                    OP_JPG:  if (!acc_neg && !acc_zero) pc_next = ea_calc + 1'b1;
                    OP_JPGE: if (!acc_neg) pc_next = ea_calc + 1'b1;
                    OP_JPL:  if (acc_neg) pc_next = ea_calc + 1'b1;
                    OP_JPLE: if (acc_neg || acc_zero) pc_next = ea_calc + 1'b1;
                    OP_JPE:  if (acc_zero) pc_next = ea_calc + 1'b1;
                    OP_JPNE: if (!acc_zero) pc_next = ea_calc + 1'b1;
                    OP_NOT:  acc_next = ~acc_reg;
                    OP_CALL:
                    begin
                        // The return address pushed is the operand word's address.
                        mem_we    = 1'b1;
                        mem_addr  = sp_dec;
                        mem_wdata = word_t'({{(WORD_BITS-ADDR_BITS){1'b0}}, p1});
                        sp_next   = sp_dec;
                        pc_next   = ea_calc + 1'b1;
                    end
                    OP_HALT:
                    begin
                        stopped_next = 1'b1;
                        pc_next      = pc_reg;
                    end
                    default:
                    begin
                        // Illegal opcode: stop on it and flag the fault.
                        stopped_next = 1'b1;
                        fault_next   = 1'b1;
                        pc_next      = pc_reg;
                    end
                endcase
            end

            S_EXEC:
            begin
                // The data word read at the effective address or at SP is back.
                state_next = S_FINISH;
                case (op_reg)
                    OP_LOAD: acc_next = rdata_reg;
                    OP_XOR:  acc_next = acc_reg ^ rdata_reg;
                    OP_AND:  acc_next = acc_reg & rdata_reg;
                    OP_OR:   acc_next = acc_reg | rdata_reg;
                    OP_ADD:  acc_next = acc_reg + rdata_reg;
                    OP_SUB:  acc_next = acc_reg - rdata_reg;
                    OP_WRITE:
                    begin
                        wvalid_next = 1'b1;
                        wvalue_next = rdata_reg;
                    end
                    OP_PUSH:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = sp_dec;
                        mem_wdata = rdata_reg;
                        sp_next   = sp_dec;
                    end
                    OP_POP:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = ea_reg;
                        mem_wdata = rdata_reg;
                        sp_next   = sp_reg + 1'b1;
                    end
                    OP_RET:
                    begin
                        pc_next = rdata_reg[ADDR_BITS-1:0] + 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                    default: ;
                endcase
            end

            S_FINISH:
            begin
                // Hand the status over once the result register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            sp_reg        <= SP_RESET;
            acc_reg       <= '0;
            stopped_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            acc_reg       <= acc_next;
            stopped_reg   <= stopped_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ea_reg      <= ea_next;
        rv_reg      <= rv_next;
        fault_reg   <= fault_next;
        wvalid_reg  <= wvalid_next;
        wvalue_reg  <= wvalue_next;
        if (rsp_load)
        begin
            rsp_out_valid_reg <= wvalid_reg;
            rsp_out_value_reg <= wvalue_reg;
            rsp_halted_reg    <= stopped_reg;
            rsp_fault_reg     <= fault_reg;
            rsp_pc_reg        <= pc_reg;
            rsp_acc_reg       <= acc_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_valid = rsp_out_valid_reg;
    assign rsp.out_value = rsp_out_value_reg;
    assign rsp.halted    = rsp_halted_reg;
    assign rsp.fault     = rsp_fault_reg;
    assign rsp.pc_now    = FADR_BITS'(rsp_pc_reg);
    assign rsp.acc_now   = rsp_acc_reg;

    // A step on a stopped machine must leave the program counter alone.
    a_stopped_pc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.action == ACT_STEP && stopped_reg)
        |=> $stable(pc_reg))
        else $error("PC moved on a step of a stopped machine");

    // The operand fetch cycle never writes memory.
    a_no_write_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ARGRD) |-> !mem_we)
        else $error("memory written during operand fetch");

    // A reported fault always comes with a halted machine.
    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (!rsp.fault || rsp.halted))
        else $error("fault reported on a running machine");

    // An output word and a fault never come from the same instruction.
    a_write_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.out_valid) |-> !rsp.fault)
        else $error("WRITE output together with fault");

    // The stack pointer only moves while an instruction executes or on restart.
    a_sp_quiet_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> $stable(sp_reg))
        else $error("SP changed outside instruction execution");

endmodule
